// ----- rtl/ssbe_pkg.sv -----
// ============================================================================
// ssbe_pkg - shared types and constants for the sector basis enumerator
// Holds the configuration register map, the decode limits, the control and
// status structs between controller and datapath, and the reciprocal table
// used by the digit divider.
// ============================================================================
package ssbe_pkg;

    // Field and decode widths
    localparam int CODE_W      = 32;
    localparam int SITES_MIN   = 3;
    localparam int SITES_MAX   = 8;
    localparam int CUTOFF_MIN  = 2;
    localparam int CUTOFF_MAX  = 8;
    localparam int DIGIT_W     = CODE_W - SITES_MIN;   // boson digit word after the shift
    localparam int SITE_IDX_W  = $clog2(SITES_MAX);
    localparam int RECIP_W     = 32;
    localparam int MOM_ACC_W   = 8;                    // unreduced momentum sum, max 224

    // Configuration port
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SITES   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TMOM    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TCHARGE = 4'd3;

    localparam logic [3:0] SITES_RST   = 4'd3;
    localparam logic [3:0] CUTOFF_RST  = 4'd5;
    localparam logic [2:0] TMOM_RST    = 3'd0;
    localparam logic [3:0] TCHARGE_RST = 4'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // take the accepted item, clear accumulators
        logic mul_step;   // estimate quotient of the digit word
        logic div_step;   // correct quotient, extract one digit, accumulate
        logic finish;     // reduce momentum, judge the sector, fill output
    } ssbe_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last_site;  // current site is the last one in use
        logic out_free;   // output register can take a new result
    } ssbe_stat_t;

    // floor(2^32 / d) for the supported radices
    function automatic logic [RECIP_W-1:0] ssbe_recip(input logic [3:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            4'd2:    r = 32'h8000_0000;
            4'd3:    r = 32'h5555_5555;
            4'd4:    r = 32'h4000_0000;
            4'd5:    r = 32'h3333_3333;
            4'd6:    r = 32'h2AAA_AAAA;
            4'd7:    r = 32'h2492_4924;
            4'd8:    r = 32'h2000_0000;
            default: r = 32'h8000_0000;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/ssbe_ctrl.sv -----
// ============================================================================
// ssbe_ctrl - sequencing controller
// Accepts one item at a time and walks the datapath through two steps per
// site (quotient estimate, then correction and accumulation) before a final
// step that writes the output register.
// ============================================================================
module ssbe_ctrl
    import ssbe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  ssbe_stat_t stat,
    output ssbe_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Hold off new items while one is being decoded
    assign in_stall = (state_reg != ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = stat.last_site ? ST_FIN : ST_MUL;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/ssbe_datapath.sv -----
// ============================================================================
// ssbe_datapath - decode datapath, configuration and output register
// Splits the boson digits off the state code one site at a time with a
// reciprocal multiply and a single correction, accumulates charge, boson
// total and momentum, then judges the sector and assigns the basis index.
// ============================================================================
module ssbe_datapath
    import ssbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // accepted item
    input  logic [CODE_W-1:0]     state_code,
    input  logic                  restart,
    // control
    input  ssbe_cmd_t             cmd,
    output ssbe_stat_t            stat,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  in_sector,
    output logic [31:0]           basis_index,
    output logic [3:0]            charge,
    output logic [2:0]            momentum,
    output logic [5:0]            boson_total
);

    // Configuration registers
    logic [3:0] sites_reg;
    logic [3:0] cutoff_reg;
    logic [2:0] tmom_reg;
    logic [3:0] tcharge_reg;

    // Working registers
    logic [SITES_MAX-1:0]  fermi_reg;
    logic [DIGIT_W-1:0]    digits_reg;
    logic [DIGIT_W-1:0]    qest_reg;
    logic [SITE_IDX_W-1:0] site_reg;
    logic [3:0]            charge_acc_reg;
    logic [5:0]            boson_acc_reg;
    logic [MOM_ACC_W-1:0]  mom_acc_reg;
    logic [31:0]           count_reg;

    // Output register
    logic        out_valid_reg;
    logic        in_sector_reg;
    logic [31:0] basis_index_reg;
    logic [3:0]  charge_reg;
    logic [2:0]  momentum_reg;
    logic [5:0]  boson_total_reg;

    // Combinational values
    logic [3:0]                 n_sites;
    logic [3:0]                 radix;
    logic [CODE_W-1:0]          code_shifted;
    logic [DIGIT_W+RECIP_W-1:0] product;
    logic [DIGIT_W+3:0]         qd;
    logic [DIGIT_W+3:0]         rem_full;
    logic [4:0]                 rem_lo;
    logic                       corr;
    logic [2:0]                 digit;
    logic                       fbit;
    logic [3:0]                 weight;
    logic [6:0]                 mom_term;
    logic [10:0]                mod_v;
    logic [10:0]                n_wide;
    logic                       ok;

    // Saturate the configured site count and radix
    always_comb
    begin
        if (sites_reg < 4'(SITES_MIN))
            n_sites = 4'(SITES_MIN);
        else if (sites_reg > 4'(SITES_MAX))
            n_sites = 4'(SITES_MAX);
        else
            n_sites = sites_reg;

        if (cutoff_reg < 4'(CUTOFF_MIN))
            radix = 4'(CUTOFF_MIN);
        else if (cutoff_reg > 4'(CUTOFF_MAX))
            radix = 4'(CUTOFF_MAX);
        else
            radix = cutoff_reg;
    end

    // Digit word is the code above the fermion bits
    assign code_shifted = state_code >> n_sites;

    // Quotient estimate, never above the true quotient and at most one below
    assign product = digits_reg * ssbe_recip(radix);

    // Remainder and correction of the estimate
    assign qd       = qest_reg * radix;
    assign rem_full = {4'd0, digits_reg} - qd;
    assign rem_lo   = rem_full[4:0];
    assign corr     = (rem_lo >= {1'b0, radix});
    assign digit    = corr ? 3'(rem_lo - {1'b0, radix}) : rem_lo[2:0];

    // Momentum contribution of this site
    assign fbit     = fermi_reg[site_reg];
    assign weight   = {3'd0, fbit} + {1'b0, digit};
    assign mom_term = site_reg * weight;

    // Reduce the momentum sum modulo the site count by shifted subtraction
    always_comb
    begin
        n_wide = {7'd0, n_sites};
        mod_v  = {3'd0, mom_acc_reg};
        for (int s = 6; s >= 0; s--)
        begin
            if (mod_v >= (n_wide << s))
                mod_v = mod_v - (n_wide << s);
        end
    end

    assign ok = (charge_acc_reg == tcharge_reg) && (mod_v[2:0] == tmom_reg)
                && (boson_acc_reg < {2'd0, radix});

    assign stat.last_site = ({1'b0, site_reg} == (n_sites - 4'd1));
    assign stat.out_free  = !out_valid_reg || !out_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sites_reg   <= SITES_RST;
            cutoff_reg  <= CUTOFF_RST;
            tmom_reg    <= TMOM_RST;
            tcharge_reg <= TCHARGE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SITES:   sites_reg   <= cfg_data;
                REG_CUTOFF:  cutoff_reg  <= cfg_data;
                REG_TMOM:    tmom_reg    <= cfg_data[2:0];
                REG_TCHARGE: tcharge_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Decode working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fermi_reg      <= state_code[SITES_MAX-1:0];
            digits_reg     <= code_shifted[DIGIT_W-1:0];
            site_reg       <= '0;
            charge_acc_reg <= '0;
            boson_acc_reg  <= '0;
            mom_acc_reg    <= '0;
        end
        if (cmd.mul_step)
            qest_reg <= product[DIGIT_W+RECIP_W-1:RECIP_W];
        if (cmd.div_step)
        begin
            digits_reg     <= qest_reg + {{(DIGIT_W-1){1'b0}}, corr};
            site_reg       <= site_reg + 1'b1;
            charge_acc_reg <= charge_acc_reg + {3'd0, fbit};
            boson_acc_reg  <= boson_acc_reg + {3'd0, digit};
            mom_acc_reg    <= mom_acc_reg + {1'b0, mom_term};
        end
    end

    // Basis counter: clear on restart, advance on each state in sector
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.load && restart)
            count_reg <= '0;
        else if (cmd.finish && ok)
            count_reg <= count_reg + 32'd1;
    end

    // Output valid: set on finish, drop once the item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            in_sector_reg   <= ok;
            basis_index_reg <= ok ? count_reg : 32'd0;
            charge_reg      <= charge_acc_reg;
            momentum_reg    <= mod_v[2:0];
            boson_total_reg <= boson_acc_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign in_sector   = in_sector_reg;
    assign basis_index = basis_index_reg;
    assign charge      = charge_reg;
    assign momentum    = momentum_reg;
    assign boson_total = boson_total_reg;

endmodule

// ----- rtl/symmetry_sector_basis_enumerator_top.sv -----
// ============================================================================
// symmetry_sector_basis_enumerator_top - lattice state sector filter
// Each accepted item takes a multiply step and a correction step per site in
// the shared digit divider, then a finish step; the input stalls until that
// step is done, and the finish step waits while the output holds a stalled result.
// The output register holds a finished result while the next item is taken.
// Reset: asynchronous, clears control, the basis counter, the configuration
// registers and the output valid.
// ============================================================================
module symmetry_sector_basis_enumerator_top
    import ssbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CODE_W-1:0]     state_code,
    input  logic                  restart,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  in_sector,
    output logic [31:0]           basis_index,
    output logic [3:0]            charge,
    output logic [2:0]            momentum,
    output logic [5:0]            boson_total
);

    ssbe_cmd_t  cmd;
    ssbe_stat_t stat;

    // Registers can always take a write
    assign cfg_ready = 1'b1;

    ssbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ssbe_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .state_code  (state_code),
        .restart     (restart),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .in_sector   (in_sector),
        .basis_index (basis_index),
        .charge      (charge),
        .momentum    (momentum),
        .boson_total (boson_total)
    );

endmodule
